FILE: hw/rtl/thsp_pkg.sv
// shared types and constants for the tar header stream parser
// no dependencies; used by every module of the block by scoped names
package thsp_pkg;

	// archive geometry
	localparam int BLOCK_BYTES = 512;
	localparam int OFF_W       = $clog2(BLOCK_BYTES);
	localparam int NAME_BYTES  = 100;
	localparam int SIZE_OFFSET = 124;
	localparam int SIZE_DIGITS = 11;

	// field widths
	localparam int BYTE_W = 8;
	localparam int SIZE_W = 33;
	localparam int SKIP_W = 34;
	localparam int KIND_W = 2;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_NAME  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ENTRY = 2'd1;
	localparam logic [KIND_W-1:0] KIND_END   = 2'd2;

	// octal digit range: ascii 0x30 .. 0x37
	localparam logic [BYTE_W-4:0] OCT_PREFIX = 5'b00110;

	// output tdata width: fields rounded up to whole bytes
	localparam int RES_BITS  = BYTE_W + SIZE_W + 1;
	localparam int TDATA_W   = ((RES_BITS + 7) / 8) * 8;

	// one byte handed to the parser
	typedef struct packed {
		logic              valid;
		logic [BYTE_W-1:0] data;
	} step_t;

	// one result item
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [BYTE_W-1:0] name_char;
		logic [SIZE_W-1:0] file_size;
		logic              bad_digit;
	} result_t;

endpackage

FILE: hw/rtl/tar_header_stream_parser.sv
// top level of the tar header stream parser: input register, parser, result register
// depends on thsp_pkg, thsp_parse and thsp_out_reg
//
// Takes one archive byte per transaction and sustains one byte per clock cycle;
// a byte waits in the input register until the result slot is free or being read and is
// parsed then; its result, if any, is registered and offered on the master side. Name
// characters, one entry report per header (at the last header byte) and one end-of-archive
// report are produced; bytes of entry data and bytes after end of archive give no
// transaction. The rate is set by the single parser update per byte between the input
// register and the result register; the input stalls only while a result waits unread.
module tar_header_stream_parser (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // data_byte[7:0]
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [thsp_pkg::TDATA_W-1:0]  m_tdata,   // name_char[7:0], file_size[40:8], bad_digit[41], zero fill
	output logic [thsp_pkg::KIND_W-1:0]   m_tuser    // kind[1:0]
);

	logic                        v_s1;
	logic [thsp_pkg::BYTE_W-1:0] byte_s1;
	logic                        advance;
	thsp_pkg::step_t             step;
	logic                        res_valid;
	thsp_pkg::result_t           res;

	// the staged byte moves on whenever the result slot is free or being read
	assign advance  = !m_tvalid || m_tready;
	assign s_tready = !v_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	assign step.valid = v_s1 && advance;
	assign step.data  = byte_s1;

	thsp_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.res_valid (res_valid),
		.res       (res)
	);

	thsp_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance),
		.res_valid (step.valid && res_valid),
		.res       (res),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule

FILE: hw/rtl/thsp_parse.sv
// header parser state and per-byte update logic
// depends on thsp_pkg for widths, geometry and result kinds
module thsp_parse (
	input  logic               clk,
	input  logic               arst_n,
	input  thsp_pkg::step_t    step,
	output logic               res_valid,
	output thsp_pkg::result_t  res
);

	localparam logic [1:0] PH_HEADER = 2'd0;
	localparam logic [1:0] PH_SKIP   = 2'd1;
	localparam logic [1:0] PH_DONE   = 2'd2;

	localparam logic [thsp_pkg::OFF_W-1:0] OFF_LAST =
		thsp_pkg::OFF_W'(thsp_pkg::BLOCK_BYTES - 1);
	localparam logic [thsp_pkg::OFF_W-1:0] OFF_NAME_END =
		thsp_pkg::OFF_W'(thsp_pkg::NAME_BYTES);
	localparam logic [thsp_pkg::OFF_W-1:0] OFF_SIZE_LO =
		thsp_pkg::OFF_W'(thsp_pkg::SIZE_OFFSET);
	localparam logic [thsp_pkg::OFF_W-1:0] OFF_SIZE_HI =
		thsp_pkg::OFF_W'(thsp_pkg::SIZE_OFFSET + thsp_pkg::SIZE_DIGITS);

	logic [1:0]                    ph_q, ph_nxt;
	logic [thsp_pkg::OFF_W-1:0]    off_q, off_nxt;
	logic                          name_end_q, name_end_nxt;
	logic [thsp_pkg::SIZE_W-1:0]   acc_q, acc_nxt;
	logic                          bad_q, bad_nxt;
	logic [thsp_pkg::SKIP_W-1:0]   skip_q, skip_nxt;

	logic [thsp_pkg::BYTE_W-1:0]   b;
	logic                          is_nul;
	logic                          is_oct;
	logic [2:0]                    digit;
	logic [thsp_pkg::SKIP_W-1:0]   skip_dec;
	logic [thsp_pkg::SKIP_W-1:0]   round_sum;
	logic [thsp_pkg::SKIP_W-1:0]   rounded;

	assign b        = step.data;
	assign is_nul   = (b == '0);
	assign is_oct   = (b[thsp_pkg::BYTE_W-1:3] == thsp_pkg::OCT_PREFIX);
	assign digit    = is_oct ? b[2:0] : 3'd0;
	assign skip_dec = skip_q - thsp_pkg::SKIP_W'(1);

	// size rounded up to whole blocks; the last header byte never lies in the size field
	assign round_sum = {1'b0, acc_q} + thsp_pkg::SKIP_W'(thsp_pkg::BLOCK_BYTES - 1);
	assign rounded   = {round_sum[thsp_pkg::SKIP_W-1:thsp_pkg::OFF_W],
		thsp_pkg::OFF_W'(0)};

	// per-byte state update and result selection
	always_comb begin
		ph_nxt       = ph_q;
		off_nxt      = off_q;
		name_end_nxt = name_end_q;
		acc_nxt      = acc_q;
		bad_nxt      = bad_q;
		skip_nxt     = skip_q;
		res_valid    = 1'b0;
		res          = '0;
		if (step.valid) begin
			case (ph_q)
				PH_SKIP: begin
					skip_nxt = skip_dec;
					if (skip_dec == '0) begin
						ph_nxt       = PH_HEADER;
						off_nxt      = '0;
						name_end_nxt = 1'b0;
						acc_nxt      = '0;
						bad_nxt      = 1'b0;
					end
				end
				PH_HEADER: begin
					if (off_q == '0 && is_nul) begin
						// empty header marks end of archive
						ph_nxt    = PH_DONE;
						res_valid = 1'b1;
						res.kind  = thsp_pkg::KIND_END;
					end else begin
						// name field
						if (off_q < OFF_NAME_END && !name_end_q) begin
							if (is_nul) begin
								name_end_nxt = 1'b1;
							end else begin
								res_valid     = 1'b1;
								res.kind      = thsp_pkg::KIND_NAME;
								res.name_char = b;
							end
						end
						// octal size field, nul restarts the value
						if (off_q >= OFF_SIZE_LO && off_q < OFF_SIZE_HI) begin
							if (is_nul) begin
								acc_nxt = '0;
								bad_nxt = 1'b0;
							end else begin
								acc_nxt = {acc_q[thsp_pkg::SIZE_W-4:0], digit};
								if (!is_oct) begin
									bad_nxt = 1'b1;
								end
							end
						end
						// last header byte: report entry and arm the skip
						if (off_q == OFF_LAST) begin
							res_valid     = 1'b1;
							res.kind      = thsp_pkg::KIND_ENTRY;
							res.name_char = '0;
							res.file_size = acc_nxt;
							res.bad_digit = bad_nxt;
							skip_nxt      = rounded;
							off_nxt       = '0;
							name_end_nxt  = 1'b0;
							acc_nxt       = '0;
							bad_nxt       = 1'b0;
							ph_nxt        = (rounded != '0) ? PH_SKIP : PH_HEADER;
						end else begin
							off_nxt = off_q + thsp_pkg::OFF_W'(1);
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// parser state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q       <= PH_HEADER;
			off_q      <= '0;
			name_end_q <= 1'b0;
			acc_q      <= '0;
			bad_q      <= 1'b0;
			skip_q     <= '0;
		end else begin
			ph_q       <= ph_nxt;
			off_q      <= off_nxt;
			name_end_q <= name_end_nxt;
			acc_q      <= acc_nxt;
			bad_q      <= bad_nxt;
			skip_q     <= skip_nxt;
		end
	end

	// no result while skipping data or after end of archive
	a_quiet_skip: assert property (@(posedge clk) disable iff (!arst_n)
		(step.valid && ph_q != PH_HEADER) |-> !res_valid)
		else $error("result produced outside header phase");

	// end of archive locks the parser
	a_end_locks: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.kind == thsp_pkg::KIND_END) |=> (ph_q == PH_DONE))
		else $error("end of archive did not enter done phase");

	// entry report restarts the block offset
	a_entry_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.kind == thsp_pkg::KIND_ENTRY) |=> (off_q == '0 && acc_q == '0))
		else $error("entry report did not restart header tracking");

	// skip phase always has bytes left to skip
	a_skip_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(ph_q == PH_SKIP) |-> (skip_q != '0))
		else $error("skip phase with empty skip count");

endmodule

FILE: hw/rtl/thsp_out_reg.sv
// result register toward the master-side stream
// depends on thsp_pkg for the result struct and tdata packing
module thsp_out_reg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  logic                          res_valid,
	input  thsp_pkg::result_t             res,
	output logic                          m_tvalid,
	output logic [thsp_pkg::TDATA_W-1:0]  m_tdata,
	output logic [thsp_pkg::KIND_W-1:0]   m_tuser
);

	logic              valid_q;
	thsp_pkg::result_t res_q;

	// result register, refilled whenever the slot frees up
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load && res_valid) begin
			res_q <= res;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tuser  = res_q.kind;
	assign m_tdata  = {(thsp_pkg::TDATA_W - thsp_pkg::RES_BITS)'(0),
		res_q.bad_digit, res_q.file_size, res_q.name_char};

endmodule
